@@ rtl/sact_pkg.sv @@
// Shared types and constants of the set-associative cache tag controller.
// Holds the cache geometry, the access and result word types and the per-set row type.
// Depends on nothing; imported by set_assoc_cache_tag_controller.
`default_nettype none

package sact_pkg;

	// Cache geometry. Sizes are powers of two.
	localparam int SETS        = 64;
	localparam int WAYS        = 4;
	localparam int BLOCK_BYTES = 64;
	localparam int ADDR_BITS   = 32;

	localparam int OFFSET_BITS = $clog2(BLOCK_BYTES);
	localparam int SET_BITS    = $clog2(SETS);
	localparam int TAG_BITS    = ADDR_BITS - OFFSET_BITS - SET_BITS;
	localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;

	localparam int AGE_BITS = 8;
	localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

	// Configuration register indexes.
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_WR_THRU      = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_WR_ALLOC     = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FIFO_REPLACE = 2'd2;

	// Access kinds.
	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	typedef struct packed {
		logic                 kind;
		logic [ADDR_BITS-1:0] address;
	} req_t;

	typedef struct packed {
		logic                 hit;
		logic [1:0]           way;
		logic                 fill;
		logic [ADDR_BITS-1:0] line_address;
		logic                 writeback;
		logic [ADDR_BITS-1:0] writeback_address;
		logic                 forward_write;
	} rsp_t;

	// One set of the tag store: all ways side by side.
	typedef struct packed {
		logic [WAYS-1:0]                valid;
		logic [WAYS-1:0]                dirty;
		logic [WAYS-1:0][TAG_BITS-1:0] tag;
		logic [WAYS-1:0][AGE_BITS-1:0] age;
	} row_t;

endpackage

`default_nettype wire

@@ rtl/set_assoc_cache_tag_controller.sv @@
// Tag and replacement-policy controller of a set-associative cache.
// Holds the tag store memory, the lookup, ageing and victim selection logic.
// Depends on sact_pkg for geometry, word types and register indexes.
//
// Pipeline: a word accepted by start is held in stage one with the set row read
// from the memory, and its result then goes to the result register with done high.
// Throughput: one word per cycle; the single tag memory read at accept and
// written in the cycle after sets this figure, and busy stays low. The receiver
// cannot stall the result.
// Reset clears every set at once through per-set valid flags; no clearing pass.
`default_nettype none

module set_assoc_cache_tag_controller
	import sact_pkg::*;
(
	input  wire  logic                    clk,
	input  wire  logic                    arst_n,
	input  wire  logic                    start,
	output       logic                    busy,
	input  wire  req_t                    request,
	output       logic                    done,
	output       rsp_t                    result,
	input  wire  logic                    cfg_we,
	input  wire  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire  logic                    cfg_data
);

	// Configuration registers.
	logic wr_thru_q;
	logic wr_alloc_q;
	logic fifo_replace_q;

	// Stage one: the accepted word and the set row read from the memory.
	logic                 valid_s1;
	req_t                 req_s1;
	row_t                 rd_row_s1;

	// Tag store. A set whose flag is clear reads as empty, so reset needs no sweep.
	row_t                 tag_mem [SETS];
	logic [SETS-1:0]      row_valid_q;

	// The row written at the last edge, forwarded to a word whose read raced it.
	logic                 wr_vld_q;
	logic [SET_BITS-1:0]  wr_set_q;
	row_t                 wr_row_q;

	// Result register.
	logic                 done_q;
	rsp_t                 result_q;

	// Combinational signals of the lookup and update.
	logic                 accept;
	logic [SET_BITS-1:0]  in_set;
	logic [SET_BITS-1:0]  set_s1;
	logic [TAG_BITS-1:0]  tag_s1;
	logic                 is_write;
	row_t                 cur_row;
	row_t                 aged_row;
	row_t                 next_row;
	logic [WAYS-1:0]      match;
	logic                 hit;
	logic [WAY_BITS-1:0]  hit_way;
	logic                 found_free;
	logic [WAY_BITS-1:0]  free_way;
	logic [WAY_BITS-1:0]  lru_way;
	logic [AGE_BITS-1:0]  lru_age;
	logic [WAY_BITS-1:0]  victim;
	rsp_t                 rsp;

	// The pipeline never stalls, so the block never refuses an access.
	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign in_set = request.address[OFFSET_BITS +: SET_BITS];

	assign set_s1   = req_s1.address[OFFSET_BITS +: SET_BITS];
	assign tag_s1   = req_s1.address[ADDR_BITS-1 -: TAG_BITS];
	assign is_write = (req_s1.kind == KIND_WRITE);

	// Configuration writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_thru_q      <= 1'b0;
			wr_alloc_q     <= 1'b1;
			fifo_replace_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WR_THRU:      wr_thru_q      <= cfg_data;
				CFG_WR_ALLOC:     wr_alloc_q     <= cfg_data;
				CFG_FIFO_REPLACE: fifo_replace_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Control flags of the two stages and the per-set valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			wr_vld_q    <= 1'b0;
			done_q      <= 1'b0;
			row_valid_q <= '0;
		end else begin
			valid_s1 <= accept;
			wr_vld_q <= valid_s1;
			done_q   <= valid_s1;
			if (valid_s1) begin
				row_valid_q[set_s1] <= 1'b1;
			end
		end
	end

	// Payload registers: captured word, forwarding copy and result.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= request;
		end
		if (valid_s1) begin
			wr_set_q <= set_s1;
			wr_row_q <= next_row;
			result_q <= rsp;
		end
	end

	// Tag memory: one read port at accept, one write port in the update cycle.
	// A read and a write of the same set at one edge return the old row, which
	// the forwarding copy then replaces.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_row_s1 <= tag_mem[in_set];
		end
		if (valid_s1) begin
			tag_mem[set_s1] <= next_row;
		end
	end

	// Pick the current view of the set: the row written at the last edge if it is
	// the same set, else the memory data, else an empty set.
	always_comb begin
		if (wr_vld_q && (wr_set_q == set_s1)) begin
			cur_row = wr_row_q;
		end else if (row_valid_q[set_s1]) begin
			cur_row = rd_row_s1;
		end else begin
			cur_row       = rd_row_s1;
			cur_row.valid = '0;
			cur_row.dirty = '0;
			cur_row.age   = '0;
		end
	end

	// Lookup and ageing. A matching valid way goes to age zero; every other
	// valid way gains one, saturating.
	always_comb begin
		aged_row = cur_row;
		hit_way  = '0;
		for (int i = 0; i < WAYS; i++) begin
			match[i] = cur_row.valid[i] && (cur_row.tag[i] == tag_s1);
			if (match[i]) begin
				hit_way         = WAY_BITS'(i);
				aged_row.age[i] = '0;
			end else if (cur_row.valid[i] && (cur_row.age[i] != AGE_MAX)) begin
				aged_row.age[i] = cur_row.age[i] + 8'd1;
			end
		end
		hit = |match;
	end

	// Victim candidates: the first invalid way, and the oldest way with the
	// lowest number winning a tie.
	always_comb begin
		found_free = 1'b0;
		free_way   = '0;
		lru_way    = '0;
		lru_age    = aged_row.age[0];
		for (int i = 0; i < WAYS; i++) begin
			if (!found_free && !aged_row.valid[i]) begin
				found_free = 1'b1;
				free_way   = WAY_BITS'(i);
			end
		end
		for (int i = 1; i < WAYS; i++) begin
			if (aged_row.age[i] > lru_age) begin
				lru_age = aged_row.age[i];
				lru_way = WAY_BITS'(i);
			end
		end
	end

	// Policy: decide the result word and the row written back to the set.
	always_comb begin
		next_row = aged_row;
		victim   = '0;

		rsp                   = '0;
		rsp.hit               = hit;
		rsp.line_address      = {req_s1.address[ADDR_BITS-1:OFFSET_BITS],
		                         {OFFSET_BITS{1'b0}}};

		if (hit) begin
			rsp.way = 2'(hit_way);
			if (is_write) begin
				if (wr_thru_q) begin
					rsp.forward_write = 1'b1;
				end else begin
					next_row.dirty[hit_way] = 1'b1;
				end
			end
		end else if (is_write && !wr_alloc_q) begin
			// Write around the cache: only the ageing changes the set.
			rsp.forward_write = 1'b1;
		end else begin
			if (found_free) begin
				victim = free_way;
			end else if (fifo_replace_q) begin
				// The line in way 0 leaves; the others move down one way.
				if (aged_row.dirty[0]) begin
					rsp.writeback         = 1'b1;
					rsp.writeback_address = {aged_row.tag[0], set_s1,
					                         {OFFSET_BITS{1'b0}}};
				end
				for (int i = 0; i < WAYS - 1; i++) begin
					next_row.valid[i] = aged_row.valid[i+1];
					next_row.dirty[i] = aged_row.dirty[i+1];
					next_row.tag[i]   = aged_row.tag[i+1];
					next_row.age[i]   = aged_row.age[i+1];
				end
				victim = WAY_BITS'(WAYS - 1);
			end else begin
				victim = lru_way;
				if (aged_row.dirty[lru_way]) begin
					rsp.writeback         = 1'b1;
					rsp.writeback_address = {aged_row.tag[lru_way], set_s1,
					                         {OFFSET_BITS{1'b0}}};
				end
			end
			next_row.valid[victim] = 1'b1;
			next_row.dirty[victim] = is_write;
			next_row.tag[victim]   = tag_s1;
			next_row.age[victim]   = '0;
			rsp.fill               = 1'b1;
			rsp.way                = 2'(victim);
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire
